### hdl/tgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgs_pkg
// Shared types and constants of the tone generator with frequency sweep.
// ----------------------------------------------------------------------------
package tgs_pkg;

  localparam int DIV_W   = 22;                 // numerator and quotient width
  localparam int CNT_W   = $clog2(DIV_W);
  localparam int FREQ_W  = 16;

  localparam logic [DIV_W-1:0]  CLK_HALF   = 22'd4000000;
  localparam logic [9:0]        MS_PER_S   = 10'd1000;

  localparam logic [FREQ_W-1:0] MIN_RESET  = 16'd100;
  localparam logic [FREQ_W-1:0] MAX_RESET  = 16'd10000;
  localparam logic [FREQ_W-1:0] STEP_RESET = 16'd100;
  localparam logic [FREQ_W-1:0] HP_RESET   = 16'(CLK_HALF / 22'(MIN_RESET));

  // request codes
  localparam logic [2:0] REQ_SET_FREQ = 3'd0;
  localparam logic [2:0] REQ_SWEEP    = 3'd1;
  localparam logic [2:0] REQ_TICK     = 3'd2;
  localparam logic [2:0] REQ_COMPARE  = 3'd3;
  localparam logic [2:0] REQ_TONE_ON  = 3'd4;
  localparam logic [2:0] REQ_RESET    = 3'd5;

  // configuration register indexes
  localparam logic [1:0] CFG_MIN  = 2'd0;
  localparam logic [1:0] CFG_MAX  = 2'd1;
  localparam logic [1:0] CFG_STEP = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HP,
    S_ACH,
    S_STEPS,
    S_MOD,
    S_DONE
  } tgs_state_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [FREQ_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quo;
  } div_rsp_t;

endpackage

### hdl/tgs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgs_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tgs_div (
  input  logic              clk,
  input  logic              rst,
  input  tgs_pkg::div_req_t req,
  output tgs_pkg::div_rsp_t rsp
);
  import tgs_pkg::*;

  logic                busy;
  logic                done;
  logic [CNT_W-1:0]    cnt;
  logic [DIV_W-1:0]    acc;
  logic [FREQ_W-1:0]   rem;
  logic [FREQ_W-1:0]   den;
  logic [FREQ_W:0]     shifted;
  logic                ge;
  logic [FREQ_W-1:0]   diff;

  // a zero divisor gives all ones, as every trial subtract succeeds
  // the remainder stays below the divisor, so the low bits of the subtract suffice
  assign shifted = {rem, acc[DIV_W-1]};
  assign ge      = shifted >= {1'b0, den};
  assign diff    = shifted[FREQ_W-1:0] - den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (req.start && !done) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W - 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      acc <= {acc[DIV_W-2:0], ge};
      rem <= ge ? diff : shifted[FREQ_W-1:0];
    end else if (req.start && !done) begin
      acc <= req.num;
      den <= req.den;
      rem <= '0;
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = acc;

endmodule

### hdl/tone_generator_with_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_generator_with_sweep
// Square-wave tone timing with a linear frequency sweep; every request
// transfer gives one status transfer on the response channel.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  req      | req_valid, req_stall | req_type, freq, period
//  rsp      | rsp_valid, rsp_stall | compare_value, half_period, freq_error,
//           |                      | step_modulo, sweep_frequency,
//           |                      | tone_enabled, sweep_enabled
//  cfg      | cfg_valid, cfg_ready | cfg_index, cfg_data
//
//  each division yields 22 quotient bits on the one serial divider; set
//  frequency runs two divisions, start sweep three, sweep tick (only while
//  sweeping) and reset one, the other requests none
//  req_stall is high from the transfer until the response is loaded
//  a finished response waits in the output register while rsp_stall is high
//  synchronous reset restores the register defaults and a 40000 half period
// ----------------------------------------------------------------------------
module tone_generator_with_sweep (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [15:0] freq,
  input  logic [6:0]  period,
  // response channel
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] compare_value,
  output logic [15:0] half_period,
  output logic [7:0]  freq_error,
  output logic [15:0] step_modulo,
  output logic [15:0] sweep_frequency,
  output logic        tone_enabled,
  output logic        sweep_enabled,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tgs_pkg::*;

  tgs_state_t state, state_next;

  // configuration registers
  logic [FREQ_W-1:0] min_freq;
  logic [FREQ_W-1:0] max_freq;
  logic [FREQ_W-1:0] freq_incr;

  // architectural state
  logic [FREQ_W-1:0] cur_compare;
  logic [FREQ_W-1:0] cur_half_period;
  logic [FREQ_W-1:0] cur_step_modulo;
  logic [FREQ_W-1:0] cur_sweep_freq;
  logic              tone_on;
  logic              sweep_on;
  logic [7:0]        err_val;
  logic [FREQ_W-1:0] steps;

  // captured request
  logic [2:0]        req_q;
  logic [FREQ_W-1:0] freq_q;
  logic [6:0]        period_q;

  logic              req_xfer;
  logic              out_load;
  logic              out_free;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  logic [FREQ_W-1:0] sweep_sum;
  logic [FREQ_W-1:0] sweep_wrapped;
  logic [FREQ_W-1:0] span;
  logic [FREQ_W-1:0] prod_full;

  assign cfg_ready = 1'b1;
  assign req_xfer  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  // sweep step wraps at 16 bits, then falls back to the minimum past max
  assign sweep_sum     = cur_sweep_freq + freq_incr;
  assign sweep_wrapped = (sweep_sum > max_freq) ? min_freq : sweep_sum;
  assign span          = max_freq - min_freq;
  // period in milliseconds, wraps at 16 bits
  assign prod_full     = FREQ_W'(period_q) * FREQ_W'(MS_PER_S);

  tgs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req_type)
            REQ_SET_FREQ, REQ_SWEEP, REQ_RESET: state_next = S_HP;
            REQ_TICK: state_next = sweep_on ? S_HP : S_DONE;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_HP: begin
        if (div_rsp.done) begin
          case (req_q)
            REQ_SET_FREQ: state_next = S_ACH;
            REQ_SWEEP: state_next = S_STEPS;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_ACH: if (div_rsp.done) state_next = S_DONE;
      S_STEPS: if (div_rsp.done) state_next = S_MOD;
      S_MOD: if (div_rsp.done) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs: divider operands, stall, response load
  always_comb begin
    div_req   = '{start: 1'b0, num: CLK_HALF, den: cur_sweep_freq};
    req_stall = 1'b1;
    out_load  = 1'b0;
    case (state)
      S_IDLE: req_stall = 1'b0;
      S_HP: begin
        div_req.start = 1'b1;
        case (req_q)
          REQ_SET_FREQ: div_req.den = freq_q;
          REQ_RESET: div_req.den = min_freq;
          default: div_req.den = cur_sweep_freq;
        endcase
      end
      S_ACH: begin
        div_req.start = 1'b1;
        div_req.den   = cur_half_period;
      end
      S_STEPS: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(span);
        div_req.den   = freq_incr;
      end
      S_MOD: begin
        div_req.start = 1'b1;
        div_req.num   = DIV_W'(prod_full);
        div_req.den   = steps;
      end
      S_DONE: out_load = out_free;
      default: req_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration writes, always accepted; the sender must keep them to idle gaps, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      min_freq  <= MIN_RESET;
      max_freq  <= MAX_RESET;
      freq_incr <= STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN: min_freq <= cfg_data;
        CFG_MAX: max_freq <= cfg_data;
        CFG_STEP: freq_incr <= cfg_data;
        default: ;
      endcase
    end
  end

  // architectural state: immediate updates at the transfer, quotients on done
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_compare     <= '0;
      cur_half_period <= HP_RESET;
      cur_step_modulo <= '0;
      cur_sweep_freq  <= '0;
      tone_on         <= 1'b0;
      sweep_on        <= 1'b0;
      err_val         <= '0;
    end else begin
      if (req_xfer) begin
        err_val <= '0;
        case (req_type)
          REQ_SET_FREQ: sweep_on <= 1'b0;
          REQ_SWEEP: begin
            cur_sweep_freq <= min_freq;
            sweep_on       <= 1'b1;
          end
          REQ_TICK: if (sweep_on) cur_sweep_freq <= sweep_wrapped;
          REQ_COMPARE: if (tone_on) cur_compare <= cur_compare + cur_half_period;
          REQ_TONE_ON: tone_on <= 1'b1;
          REQ_RESET: begin
            tone_on  <= 1'b0;
            sweep_on <= 1'b0;
          end
          default: ;
        endcase
      end
      if (div_rsp.done) begin
        case (state)
          S_HP: cur_half_period <= div_rsp.quo[FREQ_W-1:0];
          S_ACH: err_val <= div_rsp.quo[7:0] - freq_q[7:0];
          S_MOD: cur_step_modulo <= div_rsp.quo[FREQ_W-1:0] - 1'b1;
          default: ;
        endcase
      end
    end
  end

  // step count only feeds the next division
  always_ff @(posedge clk) begin
    if (div_rsp.done && state == S_STEPS) begin
      steps <= div_rsp.quo[FREQ_W-1:0];
    end
  end

  // request payload capture
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_q    <= req_type;
      freq_q   <= freq;
      period_q <= period;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      compare_value   <= cur_compare;
      half_period     <= cur_half_period;
      freq_error      <= err_val;
      step_modulo     <= cur_step_modulo;
      sweep_frequency <= cur_sweep_freq;
      tone_enabled    <= tone_on;
      sweep_enabled   <= sweep_on;
    end
  end

`ifndef SYNTH
  // tone on transfer always leaves the tone running
  a_tone_on: assert property (@(posedge clk) disable iff (rst)
    req_xfer && req_type == REQ_TONE_ON |=> tone_on)
    else $error("tone not enabled after tone on request");

  // divider results only arrive while the sequencer waits on one
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_HP || state == S_ACH ||
                      state == S_STEPS || state == S_MOD))
    else $error("divider result outside a division step");

  // a fresh response is only produced from the finish step
  a_rsp_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside the finish step");

  // no new request is taken while one is in progress
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_xfer |=> state != S_IDLE)
    else $error("sequencer idle right after a request transfer");
`endif

endmodule

### tb/tone_sweep_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_sweep_checker
// Watches the request, response and configuration channels of the tone
// generator, keeps its own model of the tone and sweep state and compares
// every response transfer field by field with the oldest predicted status.
// ----------------------------------------------------------------------------
module tone_sweep_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_stall,
  input  logic [2:0]  req_type,
  input  logic [15:0] freq,
  input  logic [6:0]  period,
  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  logic [15:0] compare_value,
  input  logic [15:0] half_period,
  input  logic [7:0]  freq_error,
  input  logic [15:0] step_modulo,
  input  logic [15:0] sweep_frequency,
  input  logic        tone_enabled,
  input  logic        sweep_enabled,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  import tgs_pkg::*;

  typedef struct packed {
    logic [15:0] compare_value;
    logic [15:0] half_period;
    logic [7:0]  freq_error;
    logic [15:0] step_modulo;
    logic [15:0] sweep_frequency;
    logic        tone_enabled;
    logic        sweep_enabled;
  } tone_status_t;

  tone_status_t status_q[$];

  // model copy of the registers and the tone state
  logic [15:0] min_f, max_f, step_f;
  logic [15:0] hp_m, cmp_m, swf_m, smod_m;
  logic        tone_m, sweep_m;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // a zero divisor gives all ones
  function automatic logic [31:0] guarded_quot(input logic [31:0] num, input logic [31:0] den);
    if (den == 32'd0) return 32'hFFFF_FFFF;
    return num / den;
  endfunction

  function automatic logic [15:0] counts_of(input logic [15:0] f);
    return 16'(guarded_quot(32'(CLK_HALF), {16'd0, f}));
  endfunction

  task automatic apply_request(input logic [2:0] kind, input logic [15:0] f,
                               input logic [6:0] p, output tone_status_t st);
    logic [31:0] achieved;
    logic [15:0] steps, prod, quot;
    logic [7:0]  err;
    err = 8'd0;
    case (kind)
      REQ_SET_FREQ: begin
        sweep_m  = 1'b0;
        hp_m     = counts_of(f);
        achieved = guarded_quot(32'(CLK_HALF), {16'd0, hp_m});
        err      = 8'(achieved - {16'd0, f});
      end
      REQ_SWEEP: begin
        swf_m   = min_f;
        hp_m    = counts_of(swf_m);
        steps   = 16'(guarded_quot({16'd0, 16'(max_f - min_f)}, {16'd0, step_f}));
        prod    = 16'(32'(p) * 32'(MS_PER_S));
        quot    = 16'(guarded_quot({16'd0, prod}, {16'd0, steps}));
        smod_m  = quot - 16'd1;
        sweep_m = 1'b1;
      end
      REQ_TICK: begin
        if (sweep_m) begin
          swf_m = swf_m + step_f;
          if (swf_m > max_f) swf_m = min_f;
          hp_m = counts_of(swf_m);
        end
      end
      REQ_COMPARE: begin
        if (tone_m) cmp_m = cmp_m + hp_m;
      end
      REQ_TONE_ON: begin
        tone_m = 1'b1;
      end
      REQ_RESET: begin
        hp_m    = counts_of(min_f);
        tone_m  = 1'b0;
        sweep_m = 1'b0;
      end
      default: begin
      end
    endcase
    st.compare_value   = cmp_m;
    st.half_period     = hp_m;
    st.freq_error      = err;
    st.step_modulo     = smod_m;
    st.sweep_frequency = swf_m;
    st.tone_enabled    = tone_m;
    st.sweep_enabled   = sweep_m;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    tone_status_t st;
    if (rst) begin
      min_f   = MIN_RESET;
      max_f   = MAX_RESET;
      step_f  = STEP_RESET;
      hp_m    = counts_of(MIN_RESET);
      cmp_m   = 16'd0;
      swf_m   = 16'd0;
      smod_m  = 16'd0;
      tone_m  = 1'b0;
      sweep_m = 1'b0;
      status_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN:  min_f  = cfg_data;
          CFG_MAX:  max_f  = cfg_data;
          CFG_STEP: step_f = cfg_data;
          default: begin
          end
        endcase
      end
      if (rsp_valid && !rsp_stall) begin
        if (status_q.size() == 0) begin
          $error("response transfer with no status outstanding");
          fail_count++;
        end else begin
          st = status_q.pop_front();
          check_field("compare_value", st.compare_value, compare_value);
          check_field("half_period", st.half_period, half_period);
          check_field("freq_error", {8'd0, st.freq_error}, {8'd0, freq_error});
          check_field("step_modulo", st.step_modulo, step_modulo);
          check_field("sweep_frequency", st.sweep_frequency, sweep_frequency);
          check_field("tone_enabled", {15'd0, st.tone_enabled}, {15'd0, tone_enabled});
          check_field("sweep_enabled", {15'd0, st.sweep_enabled}, {15'd0, sweep_enabled});
        end
      end
      if (req_valid && !req_stall) begin
        apply_request(req_type, freq, period, st);
        status_q.push_back(st);
      end
    end
    pending = status_q.size();
  end

endmodule

### tb/tb_tone_generator_with_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_generator_with_sweep
// Stimulus and verdict for the tone generator with frequency sweep: a
// directed pass over the corner cases, then random traffic under several
// register settings, idling and stall patterns, checked by tone_sweep_checker.
// ----------------------------------------------------------------------------
module tb_tone_generator_with_sweep;
  import tgs_pkg::*;

  // codes the block does not decode, reported as plain status
  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 130;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [2:0]  req_type = REQ_SET_FREQ;
  logic [15:0] freq = 16'd0;
  logic [6:0]  period = 7'd0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [15:0] compare_value;
  logic [15:0] half_period;
  logic [7:0]  freq_error;
  logic [15:0] step_modulo;
  logic [15:0] sweep_frequency;
  logic        tone_enabled;
  logic        sweep_enabled;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_MIN;
  logic [15:0] cfg_data = 16'd0;

  int fail_count;
  int pending;
  int idle_pct  = 0;   // chance in a hundred that the sender sits out a cycle
  int stall_pct = 0;   // chance in a hundred that the receiver stalls a cycle
  int cycle_count = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tone_generator_with_sweep u_dut (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_type        (req_type),
    .freq            (freq),
    .period          (period),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .compare_value   (compare_value),
    .half_period     (half_period),
    .freq_error      (freq_error),
    .step_modulo     (step_modulo),
    .sweep_frequency (sweep_frequency),
    .tone_enabled    (tone_enabled),
    .sweep_enabled   (sweep_enabled),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  tone_sweep_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .req_type        (req_type),
    .freq            (freq),
    .period          (period),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .compare_value   (compare_value),
    .half_period     (half_period),
    .freq_error      (freq_error),
    .step_modulo     (step_modulo),
    .sweep_frequency (sweep_frequency),
    .tone_enabled    (tone_enabled),
    .sweep_enabled   (sweep_enabled),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk) begin
    rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_tone_generator_with_sweep: FAIL");
      $finish;
    end
  end

  // one request transfer; entered and left at a falling edge with valid left
  // high, so back-to-back requests drop valid only for a drawn idle cycle
  task automatic push_request(input logic [2:0] kind, input logic [15:0] f,
                              input logic [6:0] p);
    while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_type  <= kind;
    freq      <= f;
    period    <= p;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // one register write; caller lowers cfg_valid after the last one
  task automatic write_register(input logic [1:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // stop sending and let every outstanding status come back
  task automatic drain_responses();
    req_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // mostly sweep ticks and compare events so that sweeps and the compare
  // accumulator get far, with set, reset and stray codes breaking them up
  task automatic random_request();
    int          sel;
    int          fsel;
    logic [2:0]  kind;
    logic [15:0] f;
    sel  = $urandom_range(99);
    fsel = $urandom_range(2);
    if (sel < 34)      kind = REQ_TICK;
    else if (sel < 58) kind = REQ_COMPARE;
    else if (sel < 66) kind = REQ_TONE_ON;
    else if (sel < 76) kind = REQ_SWEEP;
    else if (sel < 88) kind = REQ_SET_FREQ;
    else if (sel < 95) kind = REQ_RESET;
    else               kind = 3'($urandom_range(7));
    if (fsel == 0)      f = 16'($urandom_range(65535));
    else if (fsel == 1) f = 16'($urandom_range(300));
    else                f = 16'($urandom_range(20000, 62));
    push_request(kind, f, 7'($urandom_range(127)));
  endtask

  initial begin
    logic [15:0] lo, hi, stp;
    // reset held from the start, released on a falling edge
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed pass under the reset register values
    push_request(REQ_SPARE_6, 16'hFFFF, 7'h7F);   // undecoded code
    push_request(REQ_COMPARE, 16'd0, 7'd0);       // tone off, ignored
    push_request(REQ_TICK, 16'd0, 7'd0);          // sweep off, ignored
    push_request(REQ_SET_FREQ, 16'd0, 7'd0);      // zero frequency divides by zero
    push_request(REQ_SET_FREQ, 16'd1, 7'd0);      // quotient wraps at 16 bits
    push_request(REQ_SET_FREQ, 16'd61, 7'd0);     // just below the range
    push_request(REQ_SET_FREQ, 16'd62, 7'd0);
    push_request(REQ_SET_FREQ, 16'hFFFF, 7'd0);
    push_request(REQ_SET_FREQ, 16'hAAAA, 7'h55);
    push_request(REQ_SET_FREQ, 16'h5555, 7'h2A);
    push_request(REQ_TONE_ON, 16'd0, 7'd0);
    push_request(REQ_COMPARE, 16'd0, 7'd0);
    push_request(REQ_SET_FREQ, 16'd62, 7'd0);     // large half period
    push_request(REQ_COMPARE, 16'd0, 7'd0);
    push_request(REQ_COMPARE, 16'd0, 7'd0);       // accumulator wraps
    push_request(REQ_SWEEP, 16'd0, 7'd0);         // zero period, modulo underflows
    push_request(REQ_SWEEP, 16'd0, 7'd127);       // period times 1000 wraps
    push_request(REQ_SWEEP, 16'd0, 7'd65);
    push_request(REQ_TICK, 16'd0, 7'd0);
    push_request(REQ_TICK, 16'd0, 7'd0);
    push_request(REQ_COMPARE, 16'd0, 7'd0);
    push_request(REQ_RESET, 16'd0, 7'd0);
    push_request(REQ_SPARE_7, 16'd0, 7'd0);
    push_request(REQ_TICK, 16'd0, 7'd0);          // sweep stopped by reset
    push_request(REQ_COMPARE, 16'd0, 7'd0);       // tone stopped by reset
    drain_responses();

    // random phases, each under its own register setting and one of four idling and stall patterns
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin lo = 16'd62;    hi = 16'hFFFF; stp = 16'd1;     end
        1: begin lo = 16'hFFFF;  hi = 16'hFFFF; stp = 16'hFFFF; end  // no steps, add wraps
        2: begin lo = 16'd500;   hi = 16'd2000; stp = 16'd0;     end  // zero step
        3: begin lo = 16'd8000;  hi = 16'd1000; stp = 16'd300;   end  // minimum above maximum
        4: begin lo = 16'd62;    hi = 16'd62;   stp = 16'd1;     end
        5: begin lo = MIN_RESET; hi = MAX_RESET; stp = STEP_RESET; end
        6: begin
          lo  = 16'($urandom_range(2000, 62));
          hi  = lo + 16'($urandom_range(3000));
          stp = 16'($urandom_range(500, 1));
        end
        default: begin
          lo  = 16'($urandom_range(65535));
          hi  = 16'($urandom_range(65535));
          stp = 16'($urandom_range(65535));
        end
      endcase
      write_register(CFG_MIN, lo);
      write_register(CFG_MAX, hi);
      write_register(CFG_STEP, stp);
      cfg_valid <= 1'b0;

      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase

      repeat (ITEMS_PER_PHASE) random_request();
      drain_responses();
    end

    // trailing cycles catch any stray response
    idle_pct  = 0;
    stall_pct = 0;
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_tone_generator_with_sweep: PASS");
    end else begin
      $display("tb_tone_generator_with_sweep: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/tgs_pkg.sv
hdl/tgs_div.sv
hdl/tone_generator_with_sweep.sv
tb/tone_sweep_checker.sv
tb/tb_tone_generator_with_sweep.sv
